[rtl/scat_pkg.sv]
// ----------------------------------------------------------------------------
// scat_pkg: shared types and constants of the sector chain allocation table
// command codes, status codes, controller states and the controller/datapath
// command and status bundles
// ----------------------------------------------------------------------------
`default_nettype none

package scat_pkg;

	localparam int TABLE_ENTRIES_DEF = 256;
	localparam int CNT_W = 9;            // walk counter, holds up to 511
	localparam logic [7:0] MARK = 8'hFF; // empty directory entry / end of chain

	typedef enum logic [2:0] {
		CMD_NEW,
		CMD_SIZE,
		CMD_APPEND,
		CMD_LOCATE,
		CMD_WR_DIR,
		CMD_WR_LINK,
		CMD_RD_DIR,
		CMD_RD_LINK
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_FULL,
		STAT_PAST,
		STAT_CORRUPT
	} stat_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_NEW,
		S_SIZE,
		S_LOC,
		S_AP_SCAN,
		S_AP_TAIL,
		S_AP_CHK,
		S_AP_DIR,
		S_AP_LINK,
		S_AP_END,
		S_FIN
	} state_t;

	typedef enum logic [4:0] {
		OP_HOLD,
		OP_LOAD,
		OP_CLEAR,
		OP_RES_DIR,
		OP_RES_LINK,
		OP_WR_DIR,
		OP_WR_LINK,
		OP_RES_IDX,
		OP_RES_CNT,
		OP_RES_SP,
		OP_RES_N,
		OP_FAIL,
		OP_DI_INC,
		OP_WALK_START,
		OP_WALK_STEP,
		OP_TAIL_SCAN,
		OP_DIR_NUM,
		OP_WR_DIR_N,
		OP_WR_LINK_N,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		stat_t  fail;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic dir_mark;
		logic link_in;
		logic link_mark;
		logic sp_mark;
		logic new_end;
		logic cnt_size_last;
		logic cnt_tail_last;
		logic cnt_eq_pos;
		logic alloc_full;
		logic clear_last;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

[rtl/scat_ram.sv]
// ----------------------------------------------------------------------------
// scat_ram: generic simple dual-port ram
// one write port, one read port with registered read data (old data on a
// same-address write)
// ----------------------------------------------------------------------------
`default_nettype none

module scat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/scat_ctrl.sv]
// ----------------------------------------------------------------------------
// scat_ctrl: command sequencer
// steps each command through its table walks and drives the datapath
// ----------------------------------------------------------------------------
`default_nettype none

module scat_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  scat_pkg::dp_stat_t sts,
	output scat_pkg::dp_cmd_t  ctl
);

	import scat_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				case (sts.cmd)
					CMD_NEW:    state_d = S_NEW;
					CMD_SIZE:   state_d = S_SIZE;
					CMD_APPEND: state_d = S_AP_SCAN;
					CMD_LOCATE: state_d = sts.dir_mark ? S_FIN : S_LOC;
					default:    state_d = S_FIN;
				endcase
			end
			S_NEW: begin
				if (sts.new_end || sts.dir_mark) state_d = S_FIN;
			end
			S_SIZE: begin
				if (sts.sp_mark || !sts.link_in || sts.cnt_size_last) state_d = S_FIN;
			end
			S_LOC: begin
				if (!sts.link_in || sts.cnt_eq_pos || sts.link_mark) state_d = S_FIN;
			end
			S_AP_SCAN: begin
				state_d = sts.dir_mark ? S_AP_CHK : S_AP_TAIL;
			end
			S_AP_TAIL: begin
				if (!sts.link_in) state_d = S_FIN;
				else if (sts.link_mark) state_d = S_AP_SCAN;
				else if (sts.cnt_tail_last) state_d = S_FIN;
			end
			S_AP_CHK: begin
				state_d = sts.alloc_full ? S_FIN : S_AP_DIR;
			end
			S_AP_DIR: begin
				state_d = sts.dir_mark ? S_AP_END : S_AP_LINK;
			end
			S_AP_LINK: begin
				if (!sts.link_in) state_d = S_FIN;
				else if (sts.link_mark) state_d = S_AP_END;
				else if (sts.cnt_tail_last) state_d = S_FIN;
			end
			S_AP_END: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// datapath commands
	always_comb begin
		in_ready = 1'b0;
		ctl.op   = OP_HOLD;
		ctl.fail = STAT_OK;
		case (state_q)
			S_CLEAR: begin
				ctl.op = OP_CLEAR;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) ctl.op = OP_LOAD;
			end
			S_DECODE: begin
				case (sts.cmd)
					CMD_NEW:    ctl.op = OP_HOLD;
					CMD_APPEND: ctl.op = OP_HOLD;
					CMD_SIZE:   ctl.op = OP_WALK_START;
					CMD_LOCATE: begin
						if (sts.dir_mark) begin
							ctl.op   = OP_FAIL;
							ctl.fail = STAT_PAST;
						end else begin
							ctl.op = OP_WALK_START;
						end
					end
					CMD_WR_DIR:  ctl.op = OP_WR_DIR;
					CMD_WR_LINK: ctl.op = OP_WR_LINK;
					CMD_RD_DIR:  ctl.op = OP_RES_DIR;
					default:     ctl.op = OP_RES_LINK;
				endcase
			end
			S_NEW: begin
				if (sts.new_end) begin
					ctl.op   = OP_FAIL;
					ctl.fail = STAT_FULL;
				end else if (sts.dir_mark) begin
					ctl.op = OP_RES_IDX;
				end else begin
					ctl.op = OP_DI_INC;
				end
			end
			S_SIZE: begin
				if (sts.sp_mark) begin
					ctl.op = OP_RES_CNT;
				end else if (!sts.link_in || sts.cnt_size_last) begin
					ctl.op   = OP_FAIL;
					ctl.fail = STAT_CORRUPT;
				end else begin
					ctl.op = OP_WALK_STEP;
				end
			end
			S_LOC: begin
				if (!sts.link_in) begin
					ctl.op   = OP_FAIL;
					ctl.fail = STAT_CORRUPT;
				end else if (sts.cnt_eq_pos) begin
					ctl.op = OP_RES_SP;
				end else if (sts.link_mark) begin
					ctl.op   = OP_FAIL;
					ctl.fail = STAT_PAST;
				end else begin
					ctl.op = OP_WALK_STEP;
				end
			end
			S_AP_SCAN: begin
				if (!sts.dir_mark) ctl.op = OP_WALK_START;
			end
			S_AP_TAIL: begin
				if (!sts.link_in) begin
					ctl.op   = OP_FAIL;
					ctl.fail = STAT_CORRUPT;
				end else if (sts.link_mark) begin
					ctl.op = OP_TAIL_SCAN;
				end else if (sts.cnt_tail_last) begin
					ctl.op   = OP_FAIL;
					ctl.fail = STAT_CORRUPT;
				end else begin
					ctl.op = OP_WALK_STEP;
				end
			end
			S_AP_CHK: begin
				if (sts.alloc_full) begin
					ctl.op   = OP_FAIL;
					ctl.fail = STAT_FULL;
				end else begin
					ctl.op = OP_DIR_NUM;
				end
			end
			S_AP_DIR: begin
				ctl.op = sts.dir_mark ? OP_WR_DIR_N : OP_WALK_START;
			end
			S_AP_LINK: begin
				if (!sts.link_in) begin
					ctl.op   = OP_FAIL;
					ctl.fail = STAT_CORRUPT;
				end else if (sts.link_mark) begin
					ctl.op = OP_WR_LINK_N;
				end else if (sts.cnt_tail_last) begin
					ctl.op   = OP_FAIL;
					ctl.fail = STAT_CORRUPT;
				end else begin
					ctl.op = OP_WALK_STEP;
				end
			end
			S_AP_END: begin
				ctl.op = OP_RES_N;
			end
			S_FIN: begin
				if (sts.out_free) ctl.op = OP_OUT;
			end
			default: begin
				ctl.op = OP_HOLD;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/scat_dp.sv]
// ----------------------------------------------------------------------------
// scat_dp: table datapath
// directory and chain rams, walk pointers and counters, allocation compare,
// pending result and output register
// ----------------------------------------------------------------------------
`default_nettype none

module scat_dp #(
	parameter int TABLE_ENTRIES = scat_pkg::TABLE_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  scat_pkg::dp_cmd_t  ctl,
	output scat_pkg::dp_stat_t sts,
	input  logic [31:0]        in_data,
	input  logic [2:0]         in_user,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [7:0]         out_answer,
	output logic [1:0]         out_status
);

	import scat_pkg::*;

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = ((IW > 8) ? IW : 8) + 1;
	localparam int WL = (TABLE_ENTRIES < 255) ? TABLE_ENTRIES : 255;
	localparam logic [CW-1:0] TE_C = CW'(TABLE_ENTRIES);
	localparam logic [CW-1:0] TE_LAST = CW'(TABLE_ENTRIES - 1);
	localparam logic [CW-1:0] MARK_C = CW'(MARK);
	localparam logic [CNT_W-1:0] WALK_LIMIT = CNT_W'(WL);
	localparam logic [CNT_W-1:0] WALK_LAST = CNT_W'(WL - 1);

	// input word fields
	logic [7:0] in_num;
	logic [7:0] in_pos;
	logic [7:0] in_idx;
	logic [7:0] in_val;
	cmd_t       in_cmd;

	assign in_num = in_data[7:0];
	assign in_pos = in_data[15:8];
	assign in_idx = in_data[23:16];
	assign in_val = in_data[31:24];
	assign in_cmd = cmd_t'(in_user);

	cmd_t             cmd_q;
	logic [7:0]       num_q, pos_q, val_q;
	logic [CW-1:0]    di_q, di_d;
	logic [7:0]       sp_q, sp_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [7:0]       hi_q, hi_d;
	logic             hv_q, hv_d;
	logic [7:0]       ans_q, ans_d;
	stat_t            st_q, st_d;
	logic [7:0]       oans_q;
	stat_t            ost_q;
	logic             ovalid_q;
	logic             out_load;

	logic          dir_we, link_we;
	logic [IW-1:0] dir_wa, link_wa;
	logic [7:0]    dir_wd, link_wd;
	logic [7:0]    dir_rd, link_rd;
	logic          dir_in, link_in;
	logic [7:0]    dir_eff;
	logic [8:0]    n_w;

	// read addresses follow the next pointer values, so read data always
	// matches the registered pointers
	scat_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_dir_ram (
		.clk   (clk),
		.we    (dir_we),
		.waddr (dir_wa),
		.wdata (dir_wd),
		.raddr (IW'(di_d)),
		.rdata (dir_rd)
	);

	scat_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_wa),
		.wdata (link_wd),
		.raddr (IW'(sp_d)),
		.rdata (link_rd)
	);

	assign dir_in  = di_q < TE_C;
	assign link_in = CW'(sp_q) < TE_C;
	assign dir_eff = dir_in ? dir_rd : MARK;
	assign n_w     = hv_q ? ({1'b0, hi_q} + 9'd1) : 9'd0;

	always_comb begin
		di_d     = di_q;
		sp_d     = sp_q;
		cnt_d    = cnt_q;
		hi_d     = hi_q;
		hv_d     = hv_q;
		ans_d    = ans_q;
		st_d     = st_q;
		dir_we   = 1'b0;
		dir_wa   = IW'(di_q);
		dir_wd   = MARK;
		link_we  = 1'b0;
		link_wa  = IW'(di_q);
		link_wd  = MARK;
		out_load = 1'b0;
		case (ctl.op)
			OP_LOAD: begin
				hv_d = 1'b0;
				sp_d = in_idx;
				if (in_cmd inside {CMD_NEW, CMD_APPEND}) begin
					di_d = '0;
				end else if (in_cmd inside {CMD_WR_DIR, CMD_RD_DIR}) begin
					di_d = CW'(in_idx);
				end else begin
					di_d = CW'(in_num);
				end
			end
			OP_CLEAR: begin
				dir_we  = 1'b1;
				link_we = 1'b1;
				di_d    = di_q + 1'b1;
			end
			OP_RES_DIR: begin
				ans_d = dir_eff;
				st_d  = STAT_OK;
			end
			OP_RES_LINK: begin
				ans_d = link_in ? link_rd : MARK;
				st_d  = STAT_OK;
			end
			OP_WR_DIR: begin
				dir_we = dir_in;
				dir_wd = val_q;
				ans_d  = dir_in ? val_q : MARK;
				st_d   = STAT_OK;
			end
			OP_WR_LINK: begin
				link_we = link_in;
				link_wa = IW'(sp_q);
				link_wd = val_q;
				ans_d   = link_in ? val_q : MARK;
				st_d    = STAT_OK;
			end
			OP_RES_IDX: begin
				ans_d = di_q[7:0];
				st_d  = STAT_OK;
			end
			OP_RES_CNT: begin
				ans_d = cnt_q[7:0];
				st_d  = STAT_OK;
			end
			OP_RES_SP: begin
				ans_d = sp_q;
				st_d  = STAT_OK;
			end
			OP_RES_N: begin
				link_we = 1'b1;
				link_wa = IW'(n_w);
				link_wd = MARK;
				ans_d   = n_w[7:0];
				st_d    = STAT_OK;
			end
			OP_FAIL: begin
				ans_d = MARK;
				st_d  = ctl.fail;
			end
			OP_DI_INC: begin
				di_d = di_q + 1'b1;
			end
			OP_WALK_START: begin
				sp_d  = dir_eff;
				cnt_d = '0;
			end
			OP_WALK_STEP: begin
				sp_d  = link_rd;
				cnt_d = cnt_q + 1'b1;
			end
			OP_TAIL_SCAN: begin
				if (!hv_q || (sp_q > hi_q)) hi_d = sp_q;
				hv_d = 1'b1;
				di_d = di_q + 1'b1;
			end
			OP_DIR_NUM: begin
				di_d = CW'(num_q);
			end
			OP_WR_DIR_N: begin
				dir_we = 1'b1;
				dir_wd = n_w[7:0];
			end
			OP_WR_LINK_N: begin
				link_we = 1'b1;
				link_wa = IW'(sp_q);
				link_wd = n_w[7:0];
			end
			OP_OUT: begin
				out_load = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			di_q     <= '0;
			ovalid_q <= 1'b0;
		end else begin
			di_q <= di_d;
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.op == OP_LOAD) begin
			cmd_q <= in_cmd;
			num_q <= in_num;
			pos_q <= in_pos;
			val_q <= in_val;
		end
		sp_q  <= sp_d;
		cnt_q <= cnt_d;
		hi_q  <= hi_d;
		hv_q  <= hv_d;
		ans_q <= ans_d;
		st_q  <= st_d;
		if (out_load) begin
			oans_q <= ans_q;
			ost_q  <= st_q;
		end
	end

	assign sts.cmd           = cmd_q;
	assign sts.dir_mark      = dir_eff == MARK;
	assign sts.link_in       = link_in;
	assign sts.link_mark     = link_rd == MARK;
	assign sts.sp_mark       = sp_q == MARK;
	assign sts.new_end       = (di_q >= MARK_C) || (di_q >= TE_C);
	assign sts.cnt_size_last = cnt_q >= WALK_LIMIT;
	assign sts.cnt_tail_last = cnt_q >= WALK_LAST;
	assign sts.cnt_eq_pos    = cnt_q == CNT_W'(pos_q);
	assign sts.alloc_full    = (n_w >= 9'(MARK)) || (CW'(n_w) >= TE_C) || (CW'(num_q) >= TE_C);
	assign sts.clear_last    = di_q == TE_LAST;
	assign sts.out_free      = !ovalid_q || out_ready;

	assign out_valid  = ovalid_q;
	assign out_answer = oans_q;
	assign out_status = ost_q;

endmodule

`default_nettype wire

[rtl/sector_chain_allocation_table.sv]
// ----------------------------------------------------------------------------
// sector_chain_allocation_table: file directory and sector chain manager
// keeps a first-sector directory and a next-sector chain table (255 = empty
// or end) and runs new file, size, append, locate and table load/save commands
// ----------------------------------------------------------------------------
// usage
//  - command words arrive on the s_ stream, one result word per command leaves
//    on the m_ stream
//  - the tables have one read port each; a walk takes one directory entry or
//    one chain link per cycle
//  - table reads and writes: the answer is formed in the decode state and moved to
//    the output register in the finish state, then the next command can be taken
//  - new file: a directory scan up to the first empty entry; size and locate: a
//    walk of the chain, at most 255 links
//  - append: a scan of every directory entry and a walk of the chain of every file
//    before the first empty entry, then one walk of the target chain
//  - the next command is taken once the previous one has finished
//  - after reset both tables are filled with 255 by a clearing pass over every
//    entry, s_tready stays low during that pass
//  - a result waits in the output register while m_tready is low; the next
//    command is accepted and worked on meanwhile, and its result holds
//    until the register frees
// ----------------------------------------------------------------------------
`default_nettype none

module sector_chain_allocation_table #(
	parameter int TABLE_ENTRIES = scat_pkg::TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// command words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // file_number, block_position, entry_index, entry_value
	input  logic [2:0]  s_tuser,  // cmd
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // answer
	output logic [1:0]  m_tuser   // status
);

	import scat_pkg::*;

	dp_cmd_t  ctl;   // sequencer to datapath
	dp_stat_t sts;   // datapath flags back to the sequencer

	// sequencer: one state per walk, result handed over in its finish state
	scat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// datapath: both tables, walk pointers, allocation logic, output register
	scat_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.in_data    (s_tdata),
		.in_user    (s_tuser),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_answer (m_tdata),
		.out_status (m_tuser)
	);

endmodule

`default_nettype wire

[verif/scat_result_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scat_result_check: result checker for the sector chain allocation table
// keeps its own copy of the directory and the chain table, works out the
// answer and status of every accepted command word and compares each result
// word against the oldest outstanding prediction
// ----------------------------------------------------------------------------

module scat_result_check #(
	parameter int TABLE_ENTRIES = scat_pkg::TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // file_number, block_position, entry_index, entry_value
	input  logic [2:0]  s_tuser,   // cmd
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // answer
	input  logic [1:0]  m_tuser,   // status
	output int          fail_count,
	output int          pending,
	output int          ok_seen,
	output int          full_seen,
	output int          past_seen,
	output int          corrupt_seen
);

	import scat_pkg::*;

	localparam int WALK_MAX = (TABLE_ENTRIES < 255) ? TABLE_ENTRIES : 255;

	typedef struct {
		cmd_t       cmd;
		logic [7:0] answer;
		stat_t      status;
		int         seq;
	} table_answer_t;

	logic [7:0] dir_copy  [TABLE_ENTRIES];
	logic [7:0] link_copy [TABLE_ENTRIES];

	table_answer_t awaited_answers [$];
	int            cmd_seq;

	function automatic int dir_read(input int i);
		return (i < TABLE_ENTRIES) ? int'(dir_copy[i]) : int'(MARK);
	endfunction

	function automatic int link_read(input int i);
		return (i < TABLE_ENTRIES) ? int'(link_copy[i]) : int'(MARK);
	endfunction

	// follows a chain from a live start sector to its last sector
	function automatic stat_t chain_tail(input int start, output int tail);
		int s;
		int steps;
		s     = start;
		steps = 0;
		tail  = 0;
		for (int k = 0; k <= WALK_MAX; k++) begin
			if (s >= TABLE_ENTRIES)
				return STAT_CORRUPT;
			if (link_copy[s] == MARK) begin
				tail = s;
				return STAT_OK;
			end
			steps++;
			if (steps >= WALK_MAX)
				return STAT_CORRUPT;
			s = link_copy[s];
		end
		return STAT_CORRUPT;
	endfunction

	// runs one command on the local tables
	function automatic void run_table_command(input cmd_t c, input int num, input int pos,
		input int idx, input int val, output logic [7:0] answer, output stat_t status);
		int    ans;
		int    s;
		int    count;
		int    highest;
		int    t;
		int    n;
		int    d;
		stat_t r;
		bit    stop;
		ans    = MARK;
		status = STAT_OK;
		case (c)
			CMD_NEW: begin
				status = STAT_FULL;
				for (int i = 0; i < 255 && i < TABLE_ENTRIES; i++) begin
					if (status == STAT_FULL && dir_copy[i] == MARK) begin
						ans    = i;
						status = STAT_OK;
					end
				end
			end
			CMD_SIZE: begin
				s     = dir_read(num);
				count = 0;
				for (int k = 0; k <= WALK_MAX && s != MARK && status == STAT_OK; k++) begin
					if (s >= TABLE_ENTRIES) begin
						status = STAT_CORRUPT;
					end else begin
						count++;
						if (count > WALK_MAX)
							status = STAT_CORRUPT;
						else
							s = link_copy[s];
					end
				end
				ans = count;
			end
			CMD_APPEND: begin
				highest = -1;
				stop    = 1'b0;
				// highest tail over the files ahead of the first empty entry
				for (int i = 0; i < TABLE_ENTRIES && !stop; i++) begin
					d = dir_copy[i];
					if (d == MARK) begin
						stop = 1'b1;
					end else begin
						r = chain_tail(d, t);
						if (r != STAT_OK) begin
							status = r;
							stop   = 1'b1;
						end else if (t > highest) begin
							highest = t;
						end
					end
				end
				if (status == STAT_OK) begin
					n = highest + 1;
					if (n >= MARK || n >= TABLE_ENTRIES || num >= TABLE_ENTRIES) begin
						status = STAT_FULL;
					end else begin
						d = dir_copy[num];
						if (d == MARK) begin
							dir_copy[num] = n[7:0];
						end else begin
							r = chain_tail(d, t);
							if (r != STAT_OK)
								status = r;
							else
								link_copy[t] = n[7:0];
						end
						if (status == STAT_OK) begin
							link_copy[n] = MARK;
							ans = n;
						end
					end
				end
			end
			CMD_LOCATE: begin
				s = dir_read(num);
				if (s == MARK) begin
					status = STAT_PAST;
				end else begin
					for (int k = 0; k < pos && status == STAT_OK; k++) begin
						if (s >= TABLE_ENTRIES) begin
							status = STAT_CORRUPT;
						end else begin
							s = link_copy[s];
							if (s == MARK)
								status = STAT_PAST;
						end
					end
					if (status == STAT_OK) begin
						if (s >= TABLE_ENTRIES)
							status = STAT_CORRUPT;
						else
							ans = s;
					end
				end
			end
			CMD_WR_DIR: begin
				if (idx < TABLE_ENTRIES) begin
					dir_copy[idx] = val[7:0];
					ans = val;
				end
			end
			CMD_WR_LINK: begin
				if (idx < TABLE_ENTRIES) begin
					link_copy[idx] = val[7:0];
					ans = val;
				end
			end
			CMD_RD_DIR: ans = dir_read(idx);
			default:    ans = link_read(idx);
		endcase
		if (status != STAT_OK)
			ans = MARK;
		answer = ans[7:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		table_answer_t want;
		table_answer_t fresh;
		stat_t         got_status;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				dir_copy[i]  = MARK;
				link_copy[i] = MARK;
			end
			awaited_answers.delete();
			cmd_seq      = 0;
			pending      = 0;
			fail_count   = 0;
			ok_seen      = 0;
			full_seen    = 0;
			past_seen    = 0;
			corrupt_seen = 0;
		end else begin
			// result side first: a result always belongs to an older command
			if (m_tvalid && m_tready) begin
				got_status = stat_t'(m_tuser);
				if (awaited_answers.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result word with nothing outstanding: %s %02h %0d",
							$realtime, "answer/status", m_tdata, m_tuser);
				end else begin
					want = awaited_answers.pop_front();
					pending--;
					if (m_tdata !== want.answer || m_tuser !== want.status) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: command %0d (%s) answer exp %02h got %02h",
								$realtime, want.seq, want.cmd.name(), want.answer, m_tdata,
								"  status exp %s got %0d", want.status.name(), m_tuser);
					end
					case (got_status)
						STAT_OK:   ok_seen++;
						STAT_FULL: full_seen++;
						STAT_PAST: past_seen++;
						default:   corrupt_seen++;
					endcase
				end
			end
			if (s_tvalid && s_tready) begin
				fresh.cmd = cmd_t'(s_tuser);
				fresh.seq = cmd_seq;
				run_table_command(fresh.cmd, int'(s_tdata[7:0]), int'(s_tdata[15:8]),
					int'(s_tdata[23:16]), int'(s_tdata[31:24]), fresh.answer, fresh.status);
				awaited_answers.push_back(fresh);
				cmd_seq++;
				pending++;
			end
		end
	end

endmodule

[verif/tb_sector_chain_allocation_table.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sector_chain_allocation_table: stimulus and verdict for the table block
// drives command words with random gaps and result back-pressure, starting
// with a directed pass over every command and corner, then random episodes of
// file building, table loading, wiping, noise and read back, and finally a full
// directory; a separate checker predicts and compares every result word
// ----------------------------------------------------------------------------

module tb_sector_chain_allocation_table;

	import scat_pkg::*;

	localparam int RANDOM_ITEMS = 110;  // random command words after the directed pass
	localparam int HOLD_OFF     = 1500; // long receiver stall, fills the block up
	localparam int HOLD_AT      = 60;   // result count at which that stall starts
	localparam int DRAIN_CYCLES = 64;   // quiet time after the last result

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;  // file_number, block_position, entry_index, entry_value
	logic [2:0]  s_tuser  = '0;  // cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // answer
	logic [1:0]  m_tuser;        // status

	int fail_count;
	int pending;
	int ok_seen;
	int full_seen;
	int past_seen;
	int corrupt_seen;

	int words_sent = 0;
	int cmd_seen [8];
	bit fast_send  = 1'b0;  // sender runs back to back during this episode

	// 12 ns clock
	always #6 clk = ~clk;

	sector_chain_allocation_table u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	scat_result_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.fail_count   (fail_count),
		.pending      (pending),
		.ok_seen      (ok_seen),
		.full_seen    (full_seen),
		.past_seen    (past_seen),
		.corrupt_seen (corrupt_seen)
	);

	// offers one command word after a random gap and waits for its handshake;
	// with no gap tvalid simply stays high and only the data changes
	task automatic send_command(input cmd_t c, input int num, input int pos,
		input int idx, input int val);
		int gap;
		gap = fast_send ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= {val[7:0], idx[7:0], pos[7:0], num[7:0]};
		do @(posedge clk); while (!s_tready);
		words_sent++;
		cmd_seen[int'(c)]++;
	endtask

	// block position for locate: mostly near the start of a file
	function automatic int pick_block();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 254) : $urandom_range(0, 12);
	endfunction

	// entry value for table loads: end marks, short links, now and then anything
	function automatic int pick_entry_value();
		int r;
		r = $urandom_range(0, 3);
		if (r == 0)
			return MARK;
		else if (r == 3)
			return $urandom_range(0, 255);
		return $urandom_range(0, 31);
	endfunction

	// query on one of the few files that the episodes build up
	task automatic send_file_query();
		int p;
		p = $urandom_range(0, 9);
		if (p < 5)
			send_command(CMD_APPEND, $urandom_range(0, 5), $urandom_range(0, 254),
				$urandom_range(0, 255), $urandom_range(0, 255));
		else if (p == 5)
			send_command(CMD_NEW, $urandom_range(0, 254), $urandom_range(0, 254),
				$urandom_range(0, 255), $urandom_range(0, 255));
		else if (p < 8)
			send_command(CMD_SIZE, $urandom_range(0, 5), $urandom_range(0, 254),
				$urandom_range(0, 255), $urandom_range(0, 255));
		else
			send_command(CMD_LOCATE, $urandom_range(0, 5), pick_block(),
				$urandom_range(0, 255), $urandom_range(0, 255));
	endtask

	// sender: reset, directed pass, random episodes, full directory, verdict
	initial begin
		int target;
		int episode;
		int len;
		for (int i = 0; i < 8; i++)
			cmd_seen[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fresh tables, first files, corrupt chain, entry extremes
		send_command(CMD_RD_DIR,  0, 0, 0, 0);
		send_command(CMD_RD_LINK, 0, 0, 255, 0);
		send_command(CMD_NEW,     0, 0, 0, 0);
		send_command(CMD_SIZE,    0, 0, 0, 0);
		send_command(CMD_LOCATE,  0, 0, 0, 0);    // empty file, block zero
		send_command(CMD_APPEND,  0, 0, 0, 0);
		send_command(CMD_APPEND,  0, 0, 0, 0);
		send_command(CMD_APPEND,  1, 0, 0, 0);
		send_command(CMD_LOCATE,  0, 0, 0, 0);    // block zero gives the first sector
		send_command(CMD_LOCATE,  0, 1, 0, 0);
		send_command(CMD_LOCATE,  0, 2, 0, 0);    // just past the end
		send_command(CMD_LOCATE,  1, 254, 0, 0);
		send_command(CMD_SIZE,    0, 0, 0, 0);
		send_command(CMD_NEW,     0, 0, 0, 0);
		send_command(CMD_WR_LINK, 0, 0, 2, 2);    // sector linked to itself
		send_command(CMD_SIZE,    1, 0, 0, 0);
		send_command(CMD_APPEND,  0, 0, 0, 0);
		send_command(CMD_LOCATE,  1, 254, 0, 0);
		send_command(CMD_WR_LINK, 0, 0, 2, 255);
		send_command(CMD_WR_DIR,  0, 0, 254, 0);
		send_command(CMD_RD_DIR,  0, 0, 254, 0);
		send_command(CMD_SIZE,    254, 0, 0, 0);
		send_command(CMD_WR_DIR,  254, 254, 255, 255);
		send_command(CMD_WR_LINK, 254, 254, 200, 128);
		send_command(CMD_RD_LINK, 0, 0, 200, 0);

		// random episodes
		target = words_sent + RANDOM_ITEMS;
		while (words_sent < target) begin
			fast_send = ($urandom_range(0, 3) == 0);
			episode   = $urandom_range(0, 9);
			if (episode < 5) begin
				// build files: appends, sizes and lookups on a handful of file numbers
				len = $urandom_range(4, 12);
				repeat (len) send_file_query();
			end else if (episode == 5) begin
				// wipe the front of the directory so that allocation starts over
				len = $urandom_range(5, 15);
				for (int i = 0; i <= len; i++)
					send_command(CMD_WR_DIR, $urandom_range(0, 254), $urandom_range(0, 254),
						i, MARK);
			end else if (episode < 8) begin
				// load table entries, then query what they built
				len = $urandom_range(3, 8);
				repeat (len) begin
					if ($urandom_range(0, 1) == 0)
						send_command(CMD_WR_DIR, $urandom_range(0, 254), $urandom_range(0, 254),
							($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
								: $urandom_range(0, 15),
							pick_entry_value());
					else
						send_command(CMD_WR_LINK, $urandom_range(0, 254), $urandom_range(0, 254),
							($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
								: $urandom_range(0, 31),
							pick_entry_value());
				end
				len = $urandom_range(2, 4);
				repeat (len) send_file_query();
			end else if (episode == 8) begin
				// noise: any command, any field
				len = $urandom_range(1, 6);
				repeat (len)
					send_command(cmd_t'($urandom_range(0, 7)), $urandom_range(0, 254),
						$urandom_range(0, 254), $urandom_range(0, 255), $urandom_range(0, 255));
			end else begin
				// read back
				len = $urandom_range(2, 6);
				repeat (len)
					send_command(($urandom_range(0, 1) == 0) ? CMD_RD_DIR : CMD_RD_LINK,
						$urandom_range(0, 254), $urandom_range(0, 254),
						($urandom_range(0, 1) == 0) ? $urandom_range(0, 255)
							: $urandom_range(0, 31),
						0);
			end
		end

		// full directory: every file starts at the top sector, no room left
		fast_send = 1'b1;
		send_command(CMD_WR_LINK, 0, 0, 254, MARK);
		for (int i = 0; i < 255; i++)
			send_command(CMD_WR_DIR, 0, 0, i, 254);
		fast_send = 1'b0;
		send_command(CMD_NEW,    0, 0, 0, 0);
		send_command(CMD_APPEND, 3, 0, 0, 0);
		send_command(CMD_SIZE,   100, 0, 0, 0);
		send_command(CMD_LOCATE, 7, 0, 0, 0);
		send_command(CMD_LOCATE, 7, 1, 0, 0);
		s_tvalid <= 1'b0;

		// let the checker see the last word, then drain
		repeat (2) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d command words: new %0d, size %0d, append %0d, locate %0d",
			words_sent, cmd_seen[CMD_NEW], cmd_seen[CMD_SIZE], cmd_seen[CMD_APPEND],
			cmd_seen[CMD_LOCATE]);
		$display("  table writes %0d, table reads %0d",
			cmd_seen[CMD_WR_DIR] + cmd_seen[CMD_WR_LINK],
			cmd_seen[CMD_RD_DIR] + cmd_seen[CMD_RD_LINK]);
		$display("result words: %0d ok, %0d no room, %0d past end, %0d corrupt chain",
			ok_seen, full_seen, past_seen, corrupt_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// receiver: random stalls per word, calm stretches, and one long hold-off
	initial begin
		int  wait_cycles;
		int  taken;
		bit  calm;
		taken = 0;
		calm  = 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken % 40 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (taken == HOLD_AT) begin
				// long stall while the sender keeps offering words
				m_tready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end else begin
				wait_cycles = calm ? 0 : $urandom_range(0, 9);
				if (wait_cycles != 0) begin
					m_tready <= 1'b0;
					repeat (wait_cycles) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken++;
		end
	end

	// run limit
	initial begin
		#50_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
